// ----- rtl/u8f_pkg.sv -----
// shared types, constants and byte classification functions for the
// utf-8 latin fold unit; no dependencies
package u8f_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = QUEUE_AW + 1;

    localparam logic [7:0] OUT_LEN_RESET = 8'd65;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_NUL      = 8'h00;

    typedef struct packed {
        logic [7:0] held_lead;
        logic       lead_waiting;
        logic [1:0] skip_left;
        logic [7:0] emitted_count;
    } u8f_state_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       is_end;
        logic [7:0] fill_count;
    } u8f_result_t;

    function automatic logic is_four_lead(input logic [7:0] b);
        return (b & 8'hF1) == 8'hF0;
    endfunction

    function automatic logic is_long_lead(input logic [7:0] b);
        return is_four_lead(b) || ((b & 8'hF0) == 8'hE0);
    endfunction

    function automatic logic is_two_lead(input logic [7:0] b);
        return (b & 8'hE0) == 8'hC0;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & 8'hC0) == 8'h80;
    endfunction

    // latin-1 accented letters to their base letter, other bytes above 127 to a space
    function automatic logic [7:0] fold_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'hC0 && c <= 8'hC5) r = "A";
        else if (c == 8'hC7) r = "C";
        else if (c >= 8'hC8 && c <= 8'hCB) r = "E";
        else if (c >= 8'hCC && c <= 8'hCF) r = "I";
        else if (c == 8'hD1) r = "N";
        else if (c >= 8'hD2 && c <= 8'hD6) r = "O";
        else if (c >= 8'hD9 && c <= 8'hDC) r = "U";
        else if (c == 8'hDD) r = "Y";
        else if (c >= 8'hE0 && c <= 8'hE5) r = "a";
        else if (c == 8'hE7) r = "c";
        else if (c >= 8'hE8 && c <= 8'hEB) r = "e";
        else if (c >= 8'hEC && c <= 8'hEF) r = "i";
        else if (c == 8'hF1) r = "n";
        else if (c >= 8'hF2 && c <= 8'hF6) r = "o";
        else if (c >= 8'hF9 && c <= 8'hFC) r = "u";
        else if (c == 8'hFD || c == 8'hFF) r = "y";
        else if (c > 8'd127) r = CHAR_SPACE;
        return r;
    endfunction

endpackage

// ----- rtl/u8f_step.sv -----
// per-byte decode: string state and one byte in, up to two results out
// depends on u8f_pkg
module u8f_step (
    input  u8f_pkg::u8f_state_t  state_cur,
    input  logic [7:0]           in_byte,
    input  logic [7:0]           out_len,
    output u8f_pkg::u8f_state_t  state_nxt,
    output logic [1:0]           res_cnt,
    output u8f_pkg::u8f_result_t res0,
    output u8f_pkg::u8f_result_t res1
);
    import u8f_pkg::*;

    logic [7:0]  cnt1;
    logic        fresh;
    u8f_result_t end_res;
    u8f_result_t ch_res;

    always_comb begin
        state_nxt = state_cur;
        res_cnt   = 2'd0;
        res0      = '0;
        res1      = '0;
        cnt1      = state_cur.emitted_count;
        fresh     = 1'b0;
        end_res   = '0;
        ch_res    = '0;

        if (in_byte == CHAR_NUL) begin
            // flush a held lead if there is room, then the end beat
            if (state_cur.lead_waiting && (cnt1 < out_len)) begin
                res0.out_char = state_cur.held_lead;
                res_cnt       = 2'd1;
                cnt1          = cnt1 + 8'd1;
            end
            end_res.out_char   = CHAR_NUL;
            end_res.is_end     = 1'b1;
            end_res.fill_count = (cnt1 < out_len) ? (out_len - cnt1) : 8'd0;
            if (res_cnt == 2'd1) begin
                res1    = end_res;
                res_cnt = 2'd2;
            end else begin
                res0    = end_res;
                res_cnt = 2'd1;
            end
            state_nxt = '0;
        end else if (state_cur.emitted_count >= out_len) begin
            state_nxt.lead_waiting = 1'b0;
            state_nxt.skip_left    = 2'd0;
        end else if (state_cur.skip_left != 2'd0) begin
            state_nxt.skip_left = state_cur.skip_left - 2'd1;
        end else begin
            fresh = 1'b1;
            if (state_cur.lead_waiting) begin
                state_nxt.lead_waiting = 1'b0;
                res_cnt = 2'd1;
                cnt1    = cnt1 + 8'd1;
                if (is_cont(in_byte)) begin
                    fresh = 1'b0;
                    if (is_long_lead(state_cur.held_lead)) begin
                        state_nxt.skip_left = is_four_lead(state_cur.held_lead)
                                              ? 2'd2 : 2'd1;
                        res0.out_char = CHAR_SPACE;
                    end else begin
                        res0.out_char = fold_char({state_cur.held_lead[1:0],
                                                   in_byte[5:0]});
                    end
                end else begin
                    // lead without continuation goes out raw
                    res0.out_char = state_cur.held_lead;
                    if (cnt1 >= out_len) begin
                        fresh = 1'b0;
                    end
                end
            end
            if (fresh) begin
                if (is_long_lead(in_byte) || is_two_lead(in_byte)) begin
                    state_nxt.held_lead    = in_byte;
                    state_nxt.lead_waiting = 1'b1;
                end else if (cnt1 < out_len) begin
                    ch_res.out_char = (in_byte < 8'd32) ? CHAR_SPACE : in_byte;
                    if (res_cnt == 2'd0) begin
                        res0 = ch_res;
                    end else begin
                        res1 = ch_res;
                    end
                    res_cnt = res_cnt + 2'd1;
                    cnt1    = cnt1 + 8'd1;
                end
            end
            state_nxt.emitted_count = cnt1;
        end
    end

endmodule

// ----- rtl/u8f_fifo.sv -----
// small result queue, up to two pushes and one pop per cycle
// depends on u8f_pkg
module u8f_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [1:0]                    push_cnt,
    input  u8f_pkg::u8f_result_t          push_data0,
    input  u8f_pkg::u8f_result_t          push_data1,
    input  logic                          pop,
    output logic                          out_valid,
    output u8f_pkg::u8f_result_t          out_data,
    output logic [u8f_pkg::QUEUE_CW-1:0]  level
);
    import u8f_pkg::*;

    u8f_result_t          entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]  count_reg, count_next;
    logic [QUEUE_AW-1:0]  wr_ptr_p1;

    assign wr_ptr_p1 = wr_ptr_reg + QUEUE_AW'(1);
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign level     = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QUEUE_AW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + QUEUE_AW'(pop && out_valid);
        count_next  = count_reg + QUEUE_CW'(push_cnt)
                      - QUEUE_CW'(pop && out_valid);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push_data0;
        end
        if (push_cnt == 2'd2) begin
            entry_reg[wr_ptr_p1] <= push_data1;
        end
    end

endmodule

// ----- rtl/utf8_latin_fold_to_ascii_unit.sv -----
// top level of the utf-8 to ascii folding stream
// depends on u8f_pkg, u8f_step, u8f_fifo
//
// Takes a UTF-8 string one byte per beat on the s_ channel, a zero byte
// ending it, and returns ASCII characters on the m_ channel, at most out_len
// of them per string. The last beat of a string has is_end set, out_char
// zero and fill_count the number of zero bytes the consumer appends to reach
// out_len. Accented Latin-1 letters fold to their base letter, three-byte
// sequences and four-byte ones with an even lead byte become one space,
// control bytes become a space. A byte that may start a multi-byte sequence
// is held until the next byte, so one input byte gives zero, one or two
// result beats. An input byte is registered, then decoded and pushed into a
// four-entry result queue when the queue has room for two results; a new
// byte is taken every cycle while the queue has that room. out_len is
// written on the cfg_ channel (always ready) and resets to 65; write it only
// between strings with the unit drained.
module utf8_latin_fold_to_ascii_unit (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_out_len,
    // byte input
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    // character output
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_is_end,
    output logic [7:0] m_fill_count
);
    import u8f_pkg::*;

    // configuration
    logic [7:0]          out_len_reg;

    // input register
    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;

    // string state
    u8f_state_t          state_reg, state_next;

    // decode and queue
    logic                process;
    logic [1:0]          res_cnt;
    logic [1:0]          push_cnt;
    u8f_result_t         res0, res1;
    u8f_result_t         q_data;
    logic [QUEUE_CW-1:0] q_level;

    assign cfg_ready = 1'b1;

    // decode only when the queue can take a two-beat result
    assign process  = in_valid_reg && (q_level <= QUEUE_CW'(QUEUE_DEPTH - 2));
    assign s_ready  = !in_valid_reg || process;
    assign push_cnt = process ? res_cnt : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_len_reg  <= OUT_LEN_RESET;
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                out_len_reg <= cfg_out_len;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (process) begin
                state_reg <= state_next;
            end
        end
    end

    // payload register, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
    end

    u8f_step u_step (
        .state_cur (state_reg),
        .in_byte   (in_byte_reg),
        .out_len   (out_len_reg),
        .state_nxt (state_next),
        .res_cnt   (res_cnt),
        .res0      (res0),
        .res1      (res1)
    );

    u8f_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_cnt   (push_cnt),
        .push_data0 (res0),
        .push_data1 (res1),
        .pop        (m_ready),
        .out_valid  (m_valid),
        .out_data   (q_data),
        .level      (q_level)
    );

    assign m_out_char   = q_data.out_char;
    assign m_is_end     = q_data.is_end;
    assign m_fill_count = q_data.fill_count;

`ifndef SYNTHESIS
    // queue never overfills
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_level <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // a zero byte restarts the string
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        process && (in_byte_reg == CHAR_NUL)
        |=> (state_reg.emitted_count == 8'd0) && !state_reg.lead_waiting
            && (state_reg.skip_left == 2'd0))
        else $error("string state not cleared after end byte");

    // a held byte is always a lead byte
    a_held_is_lead: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.lead_waiting
        |-> (is_long_lead(state_reg.held_lead) || is_two_lead(state_reg.held_lead)))
        else $error("held byte is not a lead");

    // skipping and holding never overlap
    a_skip_no_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.skip_left != 2'd0) |-> !state_reg.lead_waiting)
        else $error("skip pending with a held lead");

    // an end byte always yields at least one beat
    a_end_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        process && (in_byte_reg == CHAR_NUL) |-> (push_cnt != 2'd0))
        else $error("end byte gave no result");
`endif

endmodule
